/* rtl/imuocs_pkg.sv */
// Shared types, codes and constants for the inertial offset calibration and scaling block.
`timescale 1ns / 1ps

package imuocs_pkg;

    localparam int RAW_W     = 16;
    localparam int OFF_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int GAIN_W    = 24;
    localparam int FRAC_BITS = 8;
    localparam int SHIFT     = GAIN_W - FRAC_BITS;
    localparam int PROD_W    = DIFF_W + GAIN_W + 1;
    localparam int OUT_W     = 19;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 16;
    localparam int SENS_W    = 15;
    localparam int CFG_W     = 24;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int N_AXES    = 6;
    localparam int N_GROUP   = 3;

    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = CNT_W'(100);
    localparam logic [SENS_W-1:0] ACCEL_SENS_RST   = SENS_W'(16384);
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST   = GAIN_W'(1024);
    localparam logic [GAIN_W-1:0] GYRO_GAIN_RST    = GAIN_W'(128070);

    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_ACCEL_SENS   = 2'd1;
    localparam logic [1:0] CFG_ACCEL_GAIN   = 2'd2;
    localparam logic [1:0] CFG_GYRO_GAIN    = 2'd3;

    typedef enum logic [1:0] {
        OP_MEAS = 2'd0,
        OP_ACAL = 2'd1,
        OP_GCAL = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic acc;
        logic restart;
        logic start;
        logic clear;
    } t_cal_ctrl;

endpackage

/* rtl/imuocs_scale_lane.sv */
// One scaling lane: offset subtraction, reciprocal gain product, rounding and saturation.
`timescale 1ns / 1ps

module imuocs_scale_lane
    import imuocs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic signed [RAW_W-1:0]  i_raw,
    input  logic signed [OFF_W-1:0]  i_off,
    input  logic [GAIN_W-1:0]        i_gain,
    output logic signed [OUT_W-1:0]  o_val
);

    localparam logic signed [PROD_W-1:0] RND     = PROD_W'(1) << (SHIFT - 1);
    localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] OUT_MIN = -(PROD_W'(1) << (OUT_W - 1));

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= DIFF_W'(i_raw) - DIFF_W'(i_off);
        end
        r_prod <= PROD_W'(r_diff) * PROD_W'(signed'({1'b0, i_gain}));
    end

    always_comb begin
        rounded = r_prod + RND;
        shifted = rounded >>> SHIFT;
        if (shifted > OUT_MAX) begin
            o_val = OUT_MAX[OUT_W-1:0];
        end else if (shifted < OUT_MIN) begin
            o_val = OUT_MIN[OUT_W-1:0];
        end else begin
            o_val = shifted[OUT_W-1:0];
        end
    end

endmodule

/* rtl/imuocs_cal_lane.sv */
// One calibration lane: running sum of an axis and a bit-serial signed divider.
`timescale 1ns / 1ps

module imuocs_cal_lane
    import imuocs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cal_ctrl                i_ctrl,
    input  logic signed [RAW_W-1:0]  i_sample,
    input  logic [CNT_W-1:0]         i_count,
    output logic signed [OFF_W-1:0]  o_quot,
    output logic                     o_done
);

    logic signed [SUM_W-1:0] r_sum;
    logic                    r_busy;
    logic                    r_done;
    logic [STEP_W-1:0]       r_step;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_div;
    logic [SUM_W-1:0]        r_q;
    logic                    r_neg;
    logic [CNT_W:0]          rem_sh;
    logic                    fits;
    logic [SUM_W-1:0]        sum_mag;
    logic [OFF_W-1:0]        q_low;

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign rem_sh  = {r_rem, r_q[SUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_div};
    assign q_low   = r_q[OFF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.clear) begin
                r_sum <= '0;
            end else if (i_ctrl.acc) begin
                r_sum <= (i_ctrl.restart ? SUM_W'(0) : r_sum) + SUM_W'(i_sample);
            end
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_STEPS - 1);
                r_rem  <= '0;
                r_div  <= i_count;
                r_q    <= sum_mag;
                r_neg  <= r_sum[SUM_W-1];
            end else if (r_busy) begin
                r_rem <= fits ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], fits};
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The mean never exceeds one raw word in magnitude, so the low bits carry it whole.
    assign o_quot = r_neg ? signed'(-q_low) : signed'(q_low);
    assign o_done = r_done;

endmodule

/* rtl/imu_offset_calibrate_scale_top.sv */
// Top level of the inertial offset calibration and scaling block.
`timescale 1ns / 1ps

// A measure word passes the subtract register and the product register of the six
// scaling lanes, then rounding and saturation, into the output register.
// A calibration word that does not finish a run goes back to idle after the calibration
// state. The word that finishes a run waits on the 32-step bit-serial dividers that
// the three calibration lanes run side by side. One word is in work at a time; the
// output register lets the next word be accepted while a result waits to be taken.
module imu_offset_calibrate_scale_top
    import imuocs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_opcode,
    input  logic signed [RAW_W-1:0]  i_accel_x,
    input  logic signed [RAW_W-1:0]  i_accel_y,
    input  logic signed [RAW_W-1:0]  i_accel_z,
    input  logic signed [RAW_W-1:0]  i_gyro_x,
    input  logic signed [RAW_W-1:0]  i_gyro_y,
    input  logic signed [RAW_W-1:0]  i_gyro_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_kind,
    output logic signed [OUT_W-1:0]  o_out_ax,
    output logic signed [OUT_W-1:0]  o_out_ay,
    output logic signed [OUT_W-1:0]  o_out_az,
    output logic signed [OUT_W-1:0]  o_out_gx,
    output logic signed [OUT_W-1:0]  o_out_gy,
    output logic signed [OUT_W-1:0]  o_out_gz
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_MOUT = 6'b000100,
        S_CAL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_COUT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]        r_sample_count;
    logic [SENS_W-1:0]       r_accel_sens;
    logic [GAIN_W-1:0]       r_accel_gain;
    logic [GAIN_W-1:0]       r_gyro_gain;
    logic [CNT_W-1:0]        r_count;
    t_op                     r_group;
    logic signed [OFF_W-1:0] r_off [N_AXES];
    logic                    r_o_valid;
    t_op                     r_kind;
    logic signed [OUT_W-1:0] r_out [N_AXES];

    t_op                     op;
    logic                    accept;
    logic                    cal_word;
    logic                    out_free;
    logic                    run_end;
    logic                    div_done;
    logic signed [RAW_W-1:0] raw [N_AXES];
    logic signed [OUT_W-1:0] scaled [N_AXES];
    logic signed [OFF_W-1:0] quot [N_GROUP];
    logic [N_GROUP-1:0]      lane_done;
    t_cal_ctrl               cal_ctrl;

    assign op       = t_op'(i_opcode);
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign cal_word = (op == OP_ACAL) || (op == OP_GCAL);
    assign out_free = !r_o_valid || i_ready;
    assign run_end  = r_count >= r_sample_count;
    assign div_done = &lane_done;

    assign raw[0] = i_accel_x;
    assign raw[1] = i_accel_y;
    assign raw[2] = i_accel_z;
    assign raw[3] = i_gyro_x;
    assign raw[4] = i_gyro_y;
    assign raw[5] = i_gyro_z;

    assign cal_ctrl.acc     = accept && cal_word;
    assign cal_ctrl.restart = r_group != op;
    assign cal_ctrl.start   = (r_state == S_CAL) && run_end;
    assign cal_ctrl.clear   = (r_state == S_DIV) && div_done;

    for (genvar g = 0; g < N_AXES; g++) begin : g_scale
        imuocs_scale_lane u_scale (
            .i_clk  (i_clk),
            .i_load (accept && (op == OP_MEAS)),
            .i_raw  (raw[g]),
            .i_off  (r_off[g]),
            .i_gain ((g < N_GROUP) ? r_accel_gain : r_gyro_gain),
            .o_val  (scaled[g])
        );
    end

    for (genvar g = 0; g < N_GROUP; g++) begin : g_cal
        imuocs_cal_lane u_cal (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (cal_ctrl),
            .i_sample ((op == OP_ACAL) ? raw[g] : raw[g + N_GROUP]),
            .i_count  (r_count),
            .o_quot   (quot[g]),
            .o_done   (lane_done[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (op == OP_MEAS)) begin
                    n_state = S_MUL;
                end else if (accept && cal_word) begin
                    n_state = S_CAL;
                end
            end
            S_MUL:  n_state = S_MOUT;
            S_MOUT: n_state = out_free ? S_IDLE : S_MOUT;
            S_CAL:  n_state = run_end ? S_DIV : S_IDLE;
            S_DIV:  n_state = div_done ? S_COUT : S_DIV;
            S_COUT: n_state = out_free ? S_IDLE : S_COUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_accel_sens   <= ACCEL_SENS_RST;
            r_accel_gain   <= ACCEL_GAIN_RST;
            r_gyro_gain    <= GYRO_GAIN_RST;
            r_count        <= '0;
            r_group        <= OP_MEAS;
            r_o_valid      <= 1'b0;
            for (int i = 0; i < N_AXES; i++) begin
                r_off[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CNT_W-1:0];
                    CFG_ACCEL_SENS:   r_accel_sens   <= i_cfg_data[SENS_W-1:0];
                    CFG_ACCEL_GAIN:   r_accel_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_GYRO_GAIN:    r_gyro_gain    <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (((r_state == S_MOUT) || (r_state == S_COUT)) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (accept && cal_word) begin
                r_count <= (cal_ctrl.restart ? CNT_W'(0) : r_count) + CNT_W'(1);
                r_group <= op;
            end
            if ((r_state == S_MOUT) && out_free) begin
                r_kind    <= OP_MEAS;
                for (int i = 0; i < N_AXES; i++) begin
                    r_out[i] <= scaled[i];
                end
            end
            if ((r_state == S_DIV) && div_done) begin
                for (int i = 0; i < N_GROUP; i++) begin
                    if (r_group != OP_ACAL) begin
                        r_off[i + N_GROUP] <= quot[i];
                    end else if (i == 2) begin
                        // Accel Z also loses one g worth of counts.
                        r_off[i] <= quot[i] - signed'(OFF_W'(r_accel_sens));
                    end else begin
                        r_off[i] <= quot[i];
                    end
                end
            end
            if ((r_state == S_COUT) && out_free) begin
                r_kind    <= r_group;
                for (int i = 0; i < N_GROUP; i++) begin
                    if (r_group == OP_ACAL) begin
                        r_out[i]           <= OUT_W'(r_off[i]);
                        r_out[i + N_GROUP] <= '0;
                    end else begin
                        r_out[i]           <= '0;
                        r_out[i + N_GROUP] <= OUT_W'(r_off[i + N_GROUP]);
                    end
                end
                r_count <= '0;
                r_group <= OP_MEAS;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_kind   = r_kind;
    assign o_out_ax = r_out[0];
    assign o_out_ay = r_out[1];
    assign o_out_az = r_out[2];
    assign o_out_gx = r_out[3];
    assign o_out_gy = r_out[4];
    assign o_out_gz = r_out[5];

endmodule

/* rtl/imuocs_checker.sv */
// Port-level checks for the calibration and scaling block, bound to its top level.
`timescale 1ns / 1ps

module imuocs_checker
    import imuocs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [1:0]               i_opcode,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [1:0]               o_kind,
    input logic signed [OUT_W-1:0]  o_out_ax,
    input logic signed [OUT_W-1:0]  o_out_ay,
    input logic signed [OUT_W-1:0]  o_out_az,
    input logic signed [OUT_W-1:0]  o_out_gx,
    input logic signed [OUT_W-1:0]  o_out_gy,
    input logic signed [OUT_W-1:0]  o_out_gz
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_out_ax)
            && $stable(o_out_gz))
        else $error("stalled output word changed");

    a_meas_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_opcode == OP_MEAS) |=> !o_ready)
        else $error("input taken while a measure word was in work");

    a_unused_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_opcode == OP_NONE) |=> o_ready)
        else $error("unused opcode stalled the input");

    a_accel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == OP_ACAL) |->
            (o_out_gx == '0) && (o_out_gy == '0) && (o_out_gz == '0))
        else $error("accel calibration word carries gyro values");

    a_gyro_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == OP_GCAL) |->
            (o_out_ax == '0) && (o_out_ay == '0) && (o_out_az == '0))
        else $error("gyro calibration word carries accel values");

endmodule

bind imu_offset_calibrate_scale_top imuocs_checker u_imuocs_checker (.*);

/* bench/tb.sv */
// Self-checking testbench for the inertial offset calibration and scaling block.
`timescale 1ns / 1ps

module tb;
    import imuocs_pkg::*;

    localparam int     CYCLE_LIMIT     = 600000;
    localparam int     SETTLE_CYCLES   = 48;
    localparam int     N_PHASES        = 8;
    localparam int     WORDS_PER_PHASE = 175;
    localparam int     N_DIRECTED      = 27;
    localparam longint OUT_HI          = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO          = -(longint'(1) <<< (OUT_W - 1));

    typedef struct packed {
        logic [1:0]                   op;
        logic [N_AXES-1:0][RAW_W-1:0] raw;
    } t_frame;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [N_AXES-1:0][OUT_W-1:0] val;
    } t_result;

    typedef struct packed {
        logic             is_cfg;
        logic [1:0]       cfg_idx;
        logic [CFG_W-1:0] cfg_data;
        t_frame           frame;
        logic             typed;
        t_result          result;
    } t_step;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_opcode;
    logic signed [RAW_W-1:0] i_accel_x;
    logic signed [RAW_W-1:0] i_accel_y;
    logic signed [RAW_W-1:0] i_accel_z;
    logic signed [RAW_W-1:0] i_gyro_x;
    logic signed [RAW_W-1:0] i_gyro_y;
    logic signed [RAW_W-1:0] i_gyro_z;
    logic                    o_valid;
    logic                    i_ready;
    logic [1:0]              o_kind;
    logic signed [OUT_W-1:0] o_out_ax;
    logic signed [OUT_W-1:0] o_out_ay;
    logic signed [OUT_W-1:0] o_out_az;
    logic signed [OUT_W-1:0] o_out_gx;
    logic signed [OUT_W-1:0] o_out_gy;
    logic signed [OUT_W-1:0] o_out_gz;

    logic [CNT_W-1:0]        sample_target;
    logic [SENS_W-1:0]       accel_sens;
    logic [GAIN_W-1:0]       accel_gain;
    logic [GAIN_W-1:0]       gyro_gain;
    logic signed [OFF_W-1:0] axis_offset [N_AXES];
    longint                  run_sums [N_GROUP];
    int                      run_count;
    logic [1:0]              run_group;

    t_result pending_results [$];
    t_result seen_result;
    t_result wanted_result;
    t_step   directed [N_DIRECTED];
    string   axis_label [N_AXES] = '{"out_ax", "out_ay", "out_az", "out_gx", "out_gy", "out_gz"};
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off_cycles = 0;

    imu_offset_calibrate_scale_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_gyro_x   (i_gyro_x),
        .i_gyro_y   (i_gyro_y),
        .i_gyro_z   (i_gyro_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_out_ax   (o_out_ax),
        .o_out_ay   (o_out_ay),
        .o_out_az   (o_out_az),
        .o_out_gx   (o_out_gx),
        .o_out_gy   (o_out_gy),
        .o_out_gz   (o_out_gz)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [OUT_W-1:0] scaled_axis(input logic [RAW_W-1:0] raw,
                                                     input logic signed [OFF_W-1:0] off,
                                                     input logic [GAIN_W-1:0] gain);
        longint prod;
        longint q;
        prod = (longint'($signed(raw)) - longint'(off)) * longint'(gain);
        q = (prod + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
        if (q > OUT_HI) q = OUT_HI;
        if (q < OUT_LO) q = OUT_LO;
        return q[OUT_W-1:0];
    endfunction

    function automatic bit calibrate_and_scale(input t_frame f, output t_result r);
        longint avg;
        int     base;
        r = '0;
        if (f.op == OP_MEAS) begin
            r.kind = OP_MEAS;
            for (int i = 0; i < N_AXES; i++)
                r.val[i] = scaled_axis(f.raw[i], axis_offset[i], (i < 3) ? accel_gain : gyro_gain);
            return 1'b1;
        end
        if (f.op == OP_NONE)
            return 1'b0;
        // A sample of the other group throws away the run in progress.
        if (run_group != f.op) begin
            for (int i = 0; i < N_GROUP; i++)
                run_sums[i] = 0;
            run_count = 0;
            run_group = f.op;
        end
        base = (f.op == OP_ACAL) ? 0 : 3;
        for (int i = 0; i < N_GROUP; i++)
            run_sums[i] += longint'($signed(f.raw[base + i]));
        run_count++;
        if (run_count < int'(sample_target))
            return 1'b0;
        r.kind = f.op;
        for (int i = 0; i < N_GROUP; i++) begin
            avg = run_sums[i] / longint'(run_count);
            if (f.op == OP_ACAL && i == 2)
                avg -= longint'(accel_sens);
            axis_offset[base + i] = avg[OFF_W-1:0];
            r.val[base + i] = avg[OUT_W-1:0];
            run_sums[i] = 0;
        end
        run_count = 0;
        run_group = OP_MEAS;
        return 1'b1;
    endfunction

    function automatic t_step word_step(input logic [1:0] op,
                                        input int ax, ay, az, gx, gy, gz);
        t_step s;
        s = '0;
        s.frame.op = op;
        s.frame.raw[0] = ax[RAW_W-1:0];
        s.frame.raw[1] = ay[RAW_W-1:0];
        s.frame.raw[2] = az[RAW_W-1:0];
        s.frame.raw[3] = gx[RAW_W-1:0];
        s.frame.raw[4] = gy[RAW_W-1:0];
        s.frame.raw[5] = gz[RAW_W-1:0];
        return s;
    endfunction

    function automatic t_step checked_step(input t_step s, input logic [1:0] kind,
                                           input int e0, e1, e2, e3, e4, e5);
        t_step c;
        c = s;
        c.typed = 1'b1;
        c.result.kind = kind;
        c.result.val[0] = e0[OUT_W-1:0];
        c.result.val[1] = e1[OUT_W-1:0];
        c.result.val[2] = e2[OUT_W-1:0];
        c.result.val[3] = e3[OUT_W-1:0];
        c.result.val[4] = e4[OUT_W-1:0];
        c.result.val[5] = e5[OUT_W-1:0];
        return c;
    endfunction

    function automatic t_step cfg_step(input logic [1:0] idx, input int data);
        t_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.cfg_idx = idx;
        s.cfg_data = data[CFG_W-1:0];
        return s;
    endfunction

    function automatic t_frame random_frame(input logic [1:0] op);
        t_frame f;
        f.op = op;
        for (int i = 0; i < N_AXES; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 3))
                        0: f.raw[i] = 16'h8000;
                        1: f.raw[i] = 16'h7FFF;
                        2: f.raw[i] = 16'h0000;
                        default: f.raw[i] = 16'hFFFF;
                    endcase
                end
                1: f.raw[i] = RAW_W'($urandom_range(0, 1023) - 512);
                default: f.raw[i] = RAW_W'($urandom_range(0, 65535));
            endcase
        end
        return f;
    endfunction

    function automatic logic [CFG_W-1:0] random_gain();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(0, 16777215));
            default: return CFG_W'($urandom_range(0, 262143));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_word(input t_frame f, input bit typed, input t_result fixed);
        t_result predicted;
        bit      has_result;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode  = f.op;
        i_accel_x = f.raw[0];
        i_accel_y = f.raw[1];
        i_accel_z = f.raw[2];
        i_gyro_x  = f.raw[3];
        i_gyro_y  = f.raw[4];
        i_gyro_z  = f.raw[5];
        i_valid   = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        has_result = calibrate_and_scale(f, predicted);
        if (has_result)
            pending_results.push_back(typed ? fixed : predicted);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SAMPLE_COUNT: sample_target = data[CNT_W-1:0];
            CFG_ACCEL_SENS:   accel_sens    = data[SENS_W-1:0];
            CFG_ACCEL_GAIN:   accel_gain    = data[GAIN_W-1:0];
            CFG_GYRO_GAIN:    gyro_gain     = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready = 1'b0;
            hold_off_cycles--;
        end else begin
            i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.kind   = o_kind;
            seen_result.val[0] = o_out_ax;
            seen_result.val[1] = o_out_ay;
            seen_result.val[2] = o_out_az;
            seen_result.val[3] = o_out_gx;
            seen_result.val[4] = o_out_gy;
            seen_result.val[5] = o_out_gz;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result of kind %0d with none expected", o_kind));
            end else begin
                wanted_result = pending_results.pop_front();
                if (seen_result.kind !== wanted_result.kind)
                    report_mismatch($sformatf("kind got %0d expected %0d",
                                              seen_result.kind, wanted_result.kind));
                for (int i = 0; i < N_AXES; i++)
                    if (seen_result.val[i] !== wanted_result.val[i])
                        report_mismatch($sformatf("%s got %0d expected %0d", axis_label[i],
                                                  $signed(seen_result.val[i]),
                                                  $signed(wanted_result.val[i])));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("imu_offset_calibrate_scale_top regression: fail");
            $finish;
        end
    end

    initial begin
        int         words_sent;
        int         pick;
        int         run_len;
        logic [1:0] grp;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_opcode   = OP_MEAS;
        i_accel_x  = '0;
        i_accel_y  = '0;
        i_accel_z  = '0;
        i_gyro_x   = '0;
        i_gyro_y   = '0;
        i_gyro_z   = '0;
        i_ready    = 1'b1;

        sample_target = SAMPLE_COUNT_RST;
        accel_sens    = ACCEL_SENS_RST;
        accel_gain    = ACCEL_GAIN_RST;
        gyro_gain     = GYRO_GAIN_RST;
        for (int i = 0; i < N_AXES; i++)
            axis_offset[i] = '0;
        for (int i = 0; i < N_GROUP; i++)
            run_sums[i] = 0;
        run_count = 0;
        run_group = OP_MEAS;

        directed = '{
            checked_step(word_step(OP_MEAS, 0, 0, 0, 0, 0, 0), OP_MEAS, 0, 0, 0, 0, 0, 0),
            word_step(OP_MEAS, 32767, 32767, 32767, 32767, 32767, 32767),
            word_step(OP_MEAS, -32768, -32768, -32768, -32768, -32768, -32768),
            word_step(OP_MEAS, 1, -1, 64, -64, 256, -257),
            word_step(OP_NONE, 12345, -777, 4242, -1, 32767, -32768),
            word_step(OP_ACAL, 100, -200, 16000, 5, 6, 7),
            word_step(OP_MEAS, 100, -200, 16000, 5, 6, 7),
            word_step(OP_GCAL, 10, -20, 30, -300, 301, 7),
            cfg_step(CFG_SAMPLE_COUNT, 1),
            word_step(OP_GCAL, 0, 0, 0, -12, 1001, -32768),
            checked_step(word_step(OP_ACAL, 0, 0, 0, 0, 0, 0), OP_ACAL, 0, 0, -16384, 0, 0, 0),
            word_step(OP_MEAS, 0, 0, 0, 0, 0, 0),
            cfg_step(CFG_ACCEL_SENS, 32767),
            cfg_step(CFG_ACCEL_GAIN, 16777215),
            cfg_step(CFG_GYRO_GAIN, 16777215),
            checked_step(word_step(OP_ACAL, -32768, -32768, -32768, -32768, -32768, -32768),
                         OP_ACAL, -32768, -32768, -65535, 0, 0, 0),
            word_step(OP_MEAS, 32767, 32767, 32767, 32767, 32767, 32767),
            word_step(OP_MEAS, -32768, -32768, -32768, -32768, -32768, -32768),
            cfg_step(CFG_ACCEL_GAIN, 0),
            cfg_step(CFG_GYRO_GAIN, 0),
            checked_step(word_step(OP_MEAS, 32767, -32768, 5, -5, 32767, -32768),
                         OP_MEAS, 0, 0, 0, 0, 0, 0),
            cfg_step(CFG_SAMPLE_COUNT, 2),
            word_step(OP_GCAL, 32767, 32767, 32767, 32767, 32767, 32767),
            checked_step(word_step(OP_GCAL, 32767, 32767, 32767, 32767, 32767, 32767),
                         OP_GCAL, 0, 0, 0, 32767, 32767, 32767),
            word_step(OP_ACAL, -1, -1, -1, -1, -1, -1),
            word_step(OP_NONE, -1, -1, -1, -1, -1, -1),
            checked_step(word_step(OP_ACAL, 0, 0, 0, 0, 0, 0), OP_ACAL, 0, 0, -32767, 0, 0, 0)
        };

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            if (directed[n].is_cfg) begin
                settle();
                write_register(directed[n].cfg_idx, directed[n].cfg_data);
            end else begin
                send_word(directed[n].frame, directed[n].typed, directed[n].result);
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle();
            // The third phase uses the longest run so that its runs are left open and
            // the next phase shortens them.
            write_register(CFG_SAMPLE_COUNT, (phase == 0) ? CFG_W'(1) :
                                             (phase == 2) ? CFG_W'(65535) :
                                             CFG_W'($urandom_range(1, 12)));
            write_register(CFG_ACCEL_SENS, (phase % 3 == 0) ? CFG_W'(1) :
                                           (phase % 3 == 1) ? CFG_W'(32767) :
                                           CFG_W'($urandom_range(1, 32767)));
            write_register(CFG_ACCEL_GAIN, random_gain());
            write_register(CFG_GYRO_GAIN, random_gain());

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (phase == 4)
                hold_off_cycles = 400;

            words_sent = 0;
            while (words_sent < WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    grp = $urandom_range(0, 1) ? OP_ACAL : OP_GCAL;
                    run_len = (sample_target > 24) ? $urandom_range(1, 24) : int'(sample_target);
                    if ($urandom_range(0, 9) == 0)
                        run_len = $urandom_range(1, run_len);
                    for (int k = 0; k < run_len; k++) begin
                        if ($urandom_range(0, 5) == 0) begin
                            send_word(random_frame(OP_MEAS), 1'b0, '0);
                            words_sent++;
                        end
                        send_word(random_frame(grp), 1'b0, '0);
                        words_sent++;
                    end
                end else if (pick < 92) begin
                    send_word(random_frame(OP_MEAS), 1'b0, '0);
                    words_sent++;
                end else if (pick < 96) begin
                    send_word(random_frame(OP_NONE), 1'b0, '0);
                end else begin
                    send_word(random_frame($urandom_range(0, 1) ? OP_ACAL : OP_GCAL), 1'b0, '0);
                    words_sent++;
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("imu_offset_calibrate_scale_top regression: pass");
        else
            $display("imu_offset_calibrate_scale_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/imuocs_pkg.sv
rtl/imuocs_scale_lane.sv
rtl/imuocs_cal_lane.sv
rtl/imu_offset_calibrate_scale_top.sv
rtl/imuocs_checker.sv
bench/tb.sv
